FILE: rtl/tpfr_pkg.sv
// Shared constants, types and the step program of the three-point frame rotator.
package tpfr_pkg;

    // Default widths of the coordinate and trig words.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_FRAC_DEF   = 30;

    // Headroom above the coordinate width for differences and rotation growth.
    localparam int GUARD_BITS = 4;

    // Normalized projection magnitudes lie in [2^(NORM_TOP-1), 2^NORM_TOP).
    localparam int NORM_TOP = 31;

    // Function codes of an input word.
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_XFORM = 1'b1;

    // Step operations.
    localparam logic [1:0] OP_TRIG = 2'd0;
    localparam logic [1:0] OP_ROT  = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // Point registers: B also holds the point of a transform word.
    localparam logic PT_B = 1'b0;
    localparam logic PT_C = 1'b1;

    // Rotation stages, in the order they are applied.
    localparam logic [1:0] STG_Z = 2'd0;
    localparam logic [1:0] STG_Y = 2'd1;
    localparam logic [1:0] STG_X = 2'd2;

    // Program entry points.
    localparam logic [3:0] PC_FRAME = 4'd0;
    localparam logic [3:0] PC_XFORM = 4'd9;

    typedef struct packed {
        logic [1:0] op;
        logic       pt;
        logic [1:0] stage;
    } step_t;

    // Status of the trig unit toward the sequencer.
    typedef struct packed {
        logic done;
        logic zero;
    } trig_stat_t;

    // Step program: frame words run from PC_FRAME, transform words from PC_XFORM.
    function automatic step_t prog(input logic [3:0] pc);
        step_t s;
        case (pc)
            4'd0:    s = '{op: OP_TRIG, pt: PT_C, stage: STG_Z};
            4'd1:    s = '{op: OP_ROT,  pt: PT_C, stage: STG_Z};
            4'd2:    s = '{op: OP_ROT,  pt: PT_B, stage: STG_Z};
            4'd3:    s = '{op: OP_TRIG, pt: PT_C, stage: STG_Y};
            4'd4:    s = '{op: OP_ROT,  pt: PT_C, stage: STG_Y};
            4'd5:    s = '{op: OP_ROT,  pt: PT_B, stage: STG_Y};
            4'd6:    s = '{op: OP_TRIG, pt: PT_B, stage: STG_X};
            4'd7:    s = '{op: OP_ROT,  pt: PT_B, stage: STG_X};
            4'd9:    s = '{op: OP_ROT,  pt: PT_B, stage: STG_Z};
            4'd10:   s = '{op: OP_ROT,  pt: PT_B, stage: STG_Y};
            4'd11:   s = '{op: OP_ROT,  pt: PT_B, stage: STG_X};
            default: s = '{op: OP_END,  pt: PT_B, stage: STG_Z};
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/tpfr_in_if.sv
// Input channel of the frame rotator: function code and three points.
interface tpfr_in_if import tpfr_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p0_z;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;

    modport source (
        output valid, func, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
        input  ready
    );

    modport sink (
        input  valid, func, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
        output ready
    );
endinterface

FILE: rtl/tpfr_out_if.sv
// Output channel of the frame rotator: one rotated point per word.
interface tpfr_out_if import tpfr_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          is_last;
    logic                          degenerate;

    modport source (
        output valid, out_x, out_y, out_z, is_last, degenerate,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, is_last, degenerate,
        output ready
    );
endinterface

FILE: rtl/tpfr_rot.sv
// Bit-serial plane rotation unit: (u, v) -> (u*c - v*s, u*s + v*c), rounded.
module tpfr_rot import tpfr_pkg::*; #(
    parameter int DW = COORD_WIDTH_DEF + GUARD_BITS,
    parameter int TF = TRIG_FRAC_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] u_in,
    input  logic signed [DW-1:0] v_in,
    input  logic signed [TF+1:0] c_in,
    input  logic signed [TF+1:0] s_in,
    output logic                 done,
    output logic signed [DW-1:0] u_out,
    output logic signed [DW-1:0] v_out
);
    localparam int TW    = TF + 2;
    localparam int PW    = DW + TF + 2;
    localparam int CNT_W = $clog2(TW);
    localparam logic [CNT_W-1:0]     LAST = CNT_W'(TW - 1);
    localparam logic signed [PW-1:0] HALF = {{(PW - TF){1'b0}}, 1'b1, {(TF - 1){1'b0}}};

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [DW-1:0] u_reg, u_next;
    logic signed [DW-1:0] v_reg, v_next;
    logic [TW-1:0]        c_sh_reg, c_sh_next;
    logic [TW-1:0]        s_sh_reg, s_sh_next;
    logic signed [PW-1:0] acc_u_reg, acc_u_next;
    logic signed [PW-1:0] acc_v_reg, acc_v_next;

    logic signed [PW-1:0] u_ext, v_ext, term_u, term_v, rnd_u, rnd_v;
    logic                 c_bit, s_bit;

    // One trig bit per cycle, most significant (negative weight) first.
    assign c_bit  = c_sh_reg[TW-1];
    assign s_bit  = s_sh_reg[TW-1];
    assign u_ext  = {{(PW - DW){u_reg[DW-1]}}, u_reg};
    assign v_ext  = {{(PW - DW){v_reg[DW-1]}}, v_reg};
    assign term_u = (c_bit ? u_ext : '0) - (s_bit ? v_ext : '0);
    assign term_v = (s_bit ? u_ext : '0) + (c_bit ? v_ext : '0);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        c_sh_next  = c_sh_reg;
        s_sh_next  = s_sh_reg;
        acc_u_next = acc_u_reg;
        acc_v_next = acc_v_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            u_next     = u_in;
            v_next     = v_in;
            c_sh_next  = c_in;
            s_sh_next  = s_in;
            acc_u_next = '0;
            acc_v_next = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                acc_u_next = -term_u;
                acc_v_next = -term_v;
            end
            else
            begin
                acc_u_next = (acc_u_reg <<< 1) + term_u;
                acc_v_next = (acc_v_reg <<< 1) + term_v;
            end
            c_sh_next = c_sh_reg << 1;
            s_sh_next = s_sh_reg << 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        v_reg     <= v_next;
        c_sh_reg  <= c_sh_next;
        s_sh_reg  <= s_sh_next;
        acc_u_reg <= acc_u_next;
        acc_v_reg <= acc_v_next;
    end

    // Round half toward +inf and drop the trig fraction bits.
    assign rnd_u = acc_u_reg + HALF;
    assign rnd_v = acc_v_reg + HALF;
    assign u_out = rnd_u[TF+DW-1:TF];
    assign v_out = rnd_v[TF+DW-1:TF];
    assign done  = done_reg;

endmodule

FILE: rtl/tpfr_trig.sv
// Cosine/sine pair unit: normalize, serial squares, serial root and two serial divides.
module tpfr_trig import tpfr_pkg::*; #(
    parameter int DW = COORD_WIDTH_DEF + GUARD_BITS,
    parameter int TF = TRIG_FRAC_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] a_in,
    input  logic signed [DW-1:0] b_in,
    output trig_stat_t           stat,
    output logic signed [TF+1:0] c_out,
    output logic signed [TF+1:0] s_out
);
    localparam int TW    = TF + 2;
    localparam int MW    = (DW > NORM_TOP) ? DW : NORM_TOP;
    localparam int SQW   = 2 * NORM_TOP + 1;
    localparam int RW    = NORM_TOP + 1;
    localparam int CMAX  = (TF > NORM_TOP) ? TF : NORM_TOP;
    localparam int CNT_W = $clog2(CMAX);
    localparam logic signed [TW-1:0] ONE = {2'b01, {TF{1'b0}}};

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_NORM  = 3'd1;
    localparam logic [2:0] T_SQ    = 3'd2;
    localparam logic [2:0] T_ROOT  = 3'd3;
    localparam logic [2:0] T_DINIT = 3'd4;
    localparam logic [2:0] T_DIV   = 3'd5;
    localparam logic [2:0] T_DRND  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [MW-1:0]        ma_reg, ma_next;
    logic [MW-1:0]        mb_reg, mb_next;
    logic                 a_neg_reg, a_neg_next;
    logic                 b_pos_reg, b_pos_next;
    logic [NORM_TOP-1:0]  sa_sh_reg, sa_sh_next;
    logic [NORM_TOP-1:0]  sb_sh_reg, sb_sh_next;
    logic [SQW-1:0]       sq_reg, sq_next;
    logic [SQW-1:0]       rt_rem_reg, rt_rem_next;
    logic [SQW-1:0]       rt_res_reg, rt_res_next;
    logic [SQW-1:0]       rt_bit_reg, rt_bit_next;
    logic [RW-1:0]        drem_reg, drem_next;
    logic [TF:0]          q_reg, q_next;
    logic                 sel_reg, sel_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [TW-1:0] c_reg, c_next;
    logic signed [TW-1:0] s_reg, s_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;

    logic [DW-1:0]        mag_a, mag_b;
    logic [MW-1:0]        m_max;
    logic                 m_over;
    logic [NORM_TOP-1:0]  na, nb, d_num;
    logic [SQW-1:0]       na_x, nb_x, sq_sum, rt_try, rt_res_step;
    logic                 rt_fit;
    logic [RW-1:0]        den, d_start;
    logic                 d_ge0, d_fit;
    logic [RW:0]          d_sh, d_sub;
    logic [TF:0]          q_rnd;
    logic signed [TW-1:0] q_s;

    // Input magnitudes.
    assign mag_a = a_in[DW-1] ? -a_in : a_in;
    assign mag_b = b_in[DW-1] ? -b_in : b_in;

    // Normalization tests on the larger magnitude.
    assign m_max  = (ma_reg > mb_reg) ? ma_reg : mb_reg;
    assign m_over = (m_max >> NORM_TOP) != '0;
    assign na     = ma_reg[NORM_TOP-1:0];
    assign nb     = mb_reg[NORM_TOP-1:0];

    // Sum of squares, one multiplier bit of each operand per cycle.
    assign na_x   = {{(SQW - NORM_TOP){1'b0}}, na};
    assign nb_x   = {{(SQW - NORM_TOP){1'b0}}, nb};
    assign sq_sum = (sq_reg << 1) + (sa_sh_reg[NORM_TOP-1] ? na_x : '0)
                  + (sb_sh_reg[NORM_TOP-1] ? nb_x : '0);

    // Integer square root, two radicand bits per cycle.
    assign rt_try      = rt_res_reg + rt_bit_reg;
    assign rt_fit      = rt_rem_reg >= rt_try;
    assign rt_res_step = rt_fit ? (rt_res_reg >> 1) + rt_bit_reg : rt_res_reg >> 1;

    // Restoring divide by the root, one quotient bit per cycle.
    assign den     = rt_res_reg[RW-1:0];
    assign d_num   = sel_reg ? nb : na;
    assign d_start = {1'b0, d_num};
    assign d_ge0   = d_start >= den;
    assign d_sh    = {drem_reg, 1'b0};
    assign d_fit   = d_sh >= {1'b0, den};
    assign d_sub   = d_sh - {1'b0, den};
    assign q_rnd   = q_reg + {{TF{1'b0}}, d_fit};
    assign q_s     = {1'b0, q_rnd};

    always_comb
    begin
        state_next  = state_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        a_neg_next  = a_neg_reg;
        b_pos_next  = b_pos_reg;
        sa_sh_next  = sa_sh_reg;
        sb_sh_next  = sb_sh_reg;
        sq_next     = sq_reg;
        rt_rem_next = rt_rem_reg;
        rt_res_next = rt_res_reg;
        rt_bit_next = rt_bit_reg;
        drem_next   = drem_reg;
        q_next      = q_reg;
        sel_next    = sel_reg;
        cnt_next    = cnt_reg;
        c_next      = c_reg;
        s_next      = s_reg;
        done_next   = 1'b0;
        zero_next   = zero_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    ma_next    = MW'(mag_a);
                    mb_next    = MW'(mag_b);
                    a_neg_next = a_in[DW-1];
                    b_pos_next = !b_in[DW-1] && (b_in != '0);
                    sel_next   = 1'b0;
                    if (a_in == '0 && b_in == '0)
                    begin
                        // Zero-length projection: identity stage.
                        c_next    = ONE;
                        s_next    = '0;
                        zero_next = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        state_next = T_NORM;
                    end
                end
            end
            T_NORM:
            begin
                if (m_over)
                begin
                    ma_next = ma_reg >> 1;
                    mb_next = mb_reg >> 1;
                end
                else if (!m_max[NORM_TOP-1])
                begin
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg << 1;
                end
                else
                begin
                    sa_sh_next = na;
                    sb_sh_next = nb;
                    sq_next    = '0;
                    cnt_next   = '0;
                    state_next = T_SQ;
                end
            end
            T_SQ:
            begin
                sq_next    = sq_sum;
                sa_sh_next = sa_sh_reg << 1;
                sb_sh_next = sb_sh_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NORM_TOP - 1))
                begin
                    rt_rem_next = sq_sum;
                    rt_res_next = '0;
                    rt_bit_next = {1'b1, {(SQW - 1){1'b0}}};
                    state_next  = T_ROOT;
                end
            end
            T_ROOT:
            begin
                if (rt_fit)
                begin
                    rt_rem_next = rt_rem_reg - rt_try;
                end
                rt_res_next = rt_res_step;
                rt_bit_next = rt_bit_reg >> 2;
                if (rt_bit_reg[0])
                begin
                    state_next = T_DINIT;
                end
            end
            T_DINIT:
            begin
                drem_next  = d_ge0 ? d_start - den : d_start;
                q_next     = {{TF{1'b0}}, d_ge0};
                cnt_next   = '0;
                state_next = T_DIV;
            end
            T_DIV:
            begin
                drem_next = d_fit ? d_sub[RW-1:0] : d_sh[RW-1:0];
                q_next    = {q_reg[TF-1:0], d_fit};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TF - 1))
                begin
                    state_next = T_DRND;
                end
            end
            T_DRND:
            begin
                if (!sel_reg)
                begin
                    c_next     = a_neg_reg ? -q_s : q_s;
                    sel_next   = 1'b1;
                    state_next = T_DINIT;
                end
                else
                begin
                    s_next     = b_pos_reg ? -q_s : q_s;
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            sel_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            zero_reg  <= zero_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        a_neg_reg  <= a_neg_next;
        b_pos_reg  <= b_pos_next;
        sa_sh_reg  <= sa_sh_next;
        sb_sh_reg  <= sb_sh_next;
        sq_reg     <= sq_next;
        rt_rem_reg <= rt_rem_next;
        rt_res_reg <= rt_res_next;
        rt_bit_reg <= rt_bit_next;
        drem_reg   <= drem_next;
        q_reg      <= q_next;
        c_reg      <= c_next;
        s_reg      <= s_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = zero_reg;
    assign c_out     = c_reg;
    assign s_out     = s_reg;

endmodule

FILE: rtl/three_point_frame_rotator.sv
// Transform words run only rotation steps; frame words also run trig steps that work out
// each stage's cosine/sine pair in the trig unit, so they take longer.
// One word is worked at a time; a finished result waits in the output register while
// the next word is accepted. Reset: identity rotations, zero origin, flag clear.
module three_point_frame_rotator import tpfr_pkg::*; #(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tpfr_in_if.sink    items,
    tpfr_out_if.source results
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + GUARD_BITS;
    localparam int TF = TRIG_FRAC_BITS;
    localparam int TW = TF + 2;
    localparam logic signed [TW-1:0] ONE = {2'b01, {TF{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_EMIT1 = 3'd3;
    localparam logic [2:0] S_EMIT2 = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [3:0]           pc_reg, pc_next;
    logic                 func_reg, func_next;
    logic signed [CW-1:0] org_x_reg, org_x_next;
    logic signed [CW-1:0] org_y_reg, org_y_next;
    logic signed [CW-1:0] org_z_reg, org_z_next;
    logic signed [TW-1:0] cos_reg [3];
    logic signed [TW-1:0] cos_next [3];
    logic signed [TW-1:0] sin_reg [3];
    logic signed [TW-1:0] sin_next [3];
    logic                 fdeg_reg, fdeg_next;
    logic                 dacc_reg, dacc_next;
    logic signed [DW-1:0] b_x_reg, b_x_next;
    logic signed [DW-1:0] b_y_reg, b_y_next;
    logic signed [DW-1:0] b_z_reg, b_z_next;
    logic signed [DW-1:0] c_x_reg, c_x_next;
    logic signed [DW-1:0] c_y_reg, c_y_next;
    logic signed [DW-1:0] c_z_reg, c_z_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [CW-1:0] out_x_reg, out_x_next;
    logic signed [CW-1:0] out_y_reg, out_y_next;
    logic signed [CW-1:0] out_z_reg, out_z_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_deg_reg, out_deg_next;

    step_t                step;
    logic signed [DW-1:0] sel_x, sel_y, sel_z, op_u, op_v;
    logic signed [TW-1:0] op_c, op_s;
    logic                 trig_start, rot_start, rot_done, out_free;
    trig_stat_t           tstat;
    logic signed [TW-1:0] trig_c, trig_s;
    logic signed [DW-1:0] rot_u, rot_v;

    function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
        return {{(DW - CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [DW-1:0] v);
        logic signed [CW-1:0] r;
        if (v[DW-1:CW-1] == '0 || v[DW-1:CW-1] == '1)
        begin
            r = v[CW-1:0];
        end
        else if (v[DW-1])
        begin
            r = {1'b1, {(CW - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CW - 1){1'b1}}};
        end
        return r;
    endfunction

    // Current step and its operands.
    assign step  = prog(pc_reg);
    assign sel_x = (step.pt == PT_C) ? c_x_reg : b_x_reg;
    assign sel_y = (step.pt == PT_C) ? c_y_reg : b_y_reg;
    assign sel_z = (step.pt == PT_C) ? c_z_reg : b_z_reg;

    always_comb
    begin
        case (step.stage)
            STG_Z:
            begin
                op_u = sel_x;
                op_v = sel_y;
                op_c = cos_reg[0];
                op_s = sin_reg[0];
            end
            STG_Y:
            begin
                op_u = sel_x;
                op_v = sel_z;
                op_c = cos_reg[1];
                op_s = sin_reg[1];
            end
            STG_X:
            begin
                op_u = sel_y;
                op_v = sel_z;
                op_c = cos_reg[2];
                op_s = sin_reg[2];
            end
            default:
            begin
                op_u = sel_x;
                op_v = sel_y;
                op_c = cos_reg[0];
                op_s = sin_reg[0];
            end
        endcase
    end

    assign trig_start = (state_reg == S_STEP) && (step.op == OP_TRIG);
    assign rot_start  = (state_reg == S_STEP) && (step.op == OP_ROT);

    tpfr_trig #(
        .DW (DW),
        .TF (TF)
    ) u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .a_in  (op_u),
        .b_in  (op_v),
        .stat  (tstat),
        .c_out (trig_c),
        .s_out (trig_s)
    );

    tpfr_rot #(
        .DW (DW),
        .TF (TF)
    ) u_rot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start),
        .u_in  (op_u),
        .v_in  (op_v),
        .c_in  (op_c),
        .s_in  (op_s),
        .done  (rot_done),
        .u_out (rot_u),
        .v_out (rot_v)
    );

    assign out_free = !out_valid_reg || results.ready;

    // Sequencer: capture a word, run its steps, then hand results to the output register.
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        func_next      = func_reg;
        org_x_next     = org_x_reg;
        org_y_next     = org_y_reg;
        org_z_next     = org_z_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        fdeg_next      = fdeg_reg;
        dacc_next      = dacc_reg;
        b_x_next       = b_x_reg;
        b_y_next       = b_y_reg;
        b_z_next       = b_z_reg;
        c_x_next       = c_x_reg;
        c_y_next       = c_y_reg;
        c_z_next       = c_z_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_last_next  = out_last_reg;
        out_deg_next   = out_deg_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    func_next  = items.func;
                    state_next = S_STEP;
                    if (items.func == FUNC_FRAME)
                    begin
                        org_x_next = items.p0_x;
                        org_y_next = items.p0_y;
                        org_z_next = items.p0_z;
                        b_x_next   = sx(items.p1_x) - sx(items.p0_x);
                        b_y_next   = sx(items.p1_y) - sx(items.p0_y);
                        b_z_next   = sx(items.p1_z) - sx(items.p0_z);
                        c_x_next   = sx(items.p2_x) - sx(items.p0_x);
                        c_y_next   = sx(items.p2_y) - sx(items.p0_y);
                        c_z_next   = sx(items.p2_z) - sx(items.p0_z);
                        dacc_next  = 1'b0;
                        pc_next    = PC_FRAME;
                    end
                    else
                    begin
                        b_x_next = sx(items.p0_x) - sx(org_x_reg);
                        b_y_next = sx(items.p0_y) - sx(org_y_reg);
                        b_z_next = sx(items.p0_z) - sx(org_z_reg);
                        pc_next  = PC_XFORM;
                    end
                end
            end
            S_STEP:
            begin
                case (step.op)
                    OP_TRIG, OP_ROT:
                    begin
                        state_next = S_WAIT;
                    end
                    default:
                    begin
                        if (func_reg == FUNC_FRAME)
                        begin
                            fdeg_next = dacc_reg;
                        end
                        state_next = S_EMIT1;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (tstat.done)
                begin
                    // Store the new pair for this stage.
                    case (step.stage)
                        STG_Z:
                        begin
                            cos_next[0] = trig_c;
                            sin_next[0] = trig_s;
                        end
                        STG_Y:
                        begin
                            cos_next[1] = trig_c;
                            sin_next[1] = trig_s;
                        end
                        default:
                        begin
                            cos_next[2] = trig_c;
                            sin_next[2] = trig_s;
                        end
                    endcase
                    dacc_next  = dacc_reg | tstat.zero;
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_STEP;
                end
                else if (rot_done)
                begin
                    // Write the rotated pair back into its point.
                    if (step.pt == PT_C)
                    begin
                        case (step.stage)
                            STG_Z:
                            begin
                                c_x_next = rot_u;
                                c_y_next = rot_v;
                            end
                            STG_Y:
                            begin
                                c_x_next = rot_u;
                                c_z_next = rot_v;
                            end
                            default:
                            begin
                                c_y_next = rot_u;
                                c_z_next = rot_v;
                            end
                        endcase
                    end
                    else
                    begin
                        case (step.stage)
                            STG_Z:
                            begin
                                b_x_next = rot_u;
                                b_y_next = rot_v;
                            end
                            STG_Y:
                            begin
                                b_x_next = rot_u;
                                b_z_next = rot_v;
                            end
                            default:
                            begin
                                b_y_next = rot_u;
                                b_z_next = rot_v;
                            end
                        endcase
                    end
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_STEP;
                end
            end
            S_EMIT1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = sat(b_x_reg);
                    out_y_next     = sat(b_y_reg);
                    out_z_next     = sat(b_z_reg);
                    out_last_next  = (func_reg == FUNC_XFORM);
                    out_deg_next   = fdeg_reg;
                    state_next     = (func_reg == FUNC_XFORM) ? S_IDLE : S_EMIT2;
                end
            end
            S_EMIT2:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = sat(c_x_reg);
                    out_y_next     = sat(c_y_reg);
                    out_z_next     = sat(c_z_reg);
                    out_last_next  = 1'b1;
                    out_deg_next   = fdeg_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= PC_FRAME;
            func_reg      <= FUNC_FRAME;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_z_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cos_reg[i] <= ONE;
                sin_reg[i] <= '0;
            end
            fdeg_reg      <= 1'b0;
            dacc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            func_reg      <= func_next;
            org_x_reg     <= org_x_next;
            org_y_reg     <= org_y_next;
            org_z_reg     <= org_z_next;
            cos_reg       <= cos_next;
            sin_reg       <= sin_next;
            fdeg_reg      <= fdeg_next;
            dacc_reg      <= dacc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_x_reg      <= b_x_next;
        b_y_reg      <= b_y_next;
        b_z_reg      <= b_z_next;
        c_x_reg      <= c_x_next;
        c_y_reg      <= c_y_next;
        c_z_reg      <= c_z_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_z_reg    <= out_z_next;
        out_last_reg <= out_last_next;
        out_deg_reg  <= out_deg_next;
    end

    // Channel outputs.
    assign items.ready        = (state_reg == S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.out_x      = out_x_reg;
    assign results.out_y      = out_y_reg;
    assign results.out_z      = out_z_reg;
    assign results.is_last    = out_last_reg;
    assign results.degenerate = out_deg_reg;

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (tstat.done || rot_done) |-> (state_reg == S_WAIT))
        else $error("Unit finished while the sequencer was not waiting.");

    a_first_word_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (state_reg == S_EMIT2))
        else $error("First frame word pending without the second queued behind it.");

    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> !items.ready)
        else $error("Input accepted again before the word was worked.");
`endif

endmodule

FILE: verif/tpfr_checker.sv
// Checker of the frame rotator: predicts each result word from accepted input words and compares.
module tpfr_checker import tpfr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    tpfr_in_if   items,
    tpfr_out_if  results,
    output int   fail_count,
    output int   pending_count,
    output int   frames_seen,
    output int   points_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int TF = TRIG_FRAC_DEF;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
        logic                 degen;
    } point_word_t;

    // Expected result words, oldest first.
    point_word_t rotated_q[$];

    // Predicted frame state.
    longint org_x, org_y, org_z;
    longint cos_t[3];
    longint sin_t[3];
    bit     degen_flag;

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Integer square root, bit by bit.
    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rounded quotient num / den with TF fraction bits, for num <= den.
    function automatic longint unsigned trig_ratio(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned q, rem;
        q = (num >= den) ? 1 : 0;
        rem = num - q * den;
        for (int i = 0; i < TF; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 1;
            end
        end
        if ((rem << 1) >= den) q = q + 1;
        return q;
    endfunction

    // Cosine and sine that zero the b component; returns 1 on a zero-length projection.
    function automatic bit angle_pair(input longint a, input longint b,
                                      output longint c, output longint s);
        longint unsigned ua, ub, m, r, cm, sm;
        ua = abs64(a);
        ub = abs64(b);
        if (ua == 0 && ub == 0)
        begin
            c = longint'(1) << TF;
            s = 0;
            return 1'b1;
        end
        m = (ua > ub) ? ua : ub;
        while (m >= (64'd1 << 31))
        begin
            ua = ua >> 1;
            ub = ub >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 30))
        begin
            ua = ua << 1;
            ub = ub << 1;
            m = m << 1;
        end
        r = root64(ua * ua + ub * ub);
        cm = trig_ratio(ua, r);
        sm = trig_ratio(ub, r);
        c = (a < 0) ? -longint'(cm) : longint'(cm);
        s = (b > 0) ? -longint'(sm) : longint'(sm);
        return 1'b0;
    endfunction

    // Exact products, rounded shift, then clamp to 64 bits.
    function automatic longint mac_round(input longint u, input longint k1,
                                         input longint v, input longint k2,
                                         input bit subtract);
        logic signed [127:0] wu, wv, w1, w2, acc, hi, lo;
        wu = u;
        wv = v;
        w1 = k1;
        w2 = k2;
        hi = 64'sh7FFFFFFFFFFFFFFF;
        lo = -hi - 1;
        acc = subtract ? (wu * w1 - wv * w2) : (wu * w1 + wv * w2);
        acc = acc + (128'sd1 <<< (TF - 1));
        acc = acc >>> TF;
        if (acc > hi) return hi[63:0];
        if (acc < lo) return lo[63:0];
        return acc[63:0];
    endfunction

    task automatic rotate_pair(inout longint u, inout longint v,
                               input longint c, input longint s);
        longint nu, nv;
        nu = mac_round(u, c, v, s, 1'b1);
        nv = mac_round(u, s, v, c, 1'b0);
        u = nu;
        v = nv;
    endtask

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint hi, lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    task automatic push_point(input longint x, input longint y, input longint z,
                              input bit last);
        point_word_t w;
        w.x = clamp_coord(x);
        w.y = clamp_coord(y);
        w.z = clamp_coord(z);
        w.last = last;
        w.degen = degen_flag;
        rotated_q.push_back(w);
    endtask

    // Work out the result words of one accepted input word.
    task automatic predict_rotation();
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        bit deg;
        ax = longint'(items.p0_x);
        ay = longint'(items.p0_y);
        az = longint'(items.p0_z);
        if (items.func == FUNC_FRAME)
        begin
            bx = longint'(items.p1_x) - ax;
            by = longint'(items.p1_y) - ay;
            bz = longint'(items.p1_z) - az;
            cx = longint'(items.p2_x) - ax;
            cy = longint'(items.p2_y) - ay;
            cz = longint'(items.p2_z) - az;
            org_x = ax;
            org_y = ay;
            org_z = az;
            deg = angle_pair(cx, cy, cos_t[0], sin_t[0]);
            rotate_pair(cx, cy, cos_t[0], sin_t[0]);
            rotate_pair(bx, by, cos_t[0], sin_t[0]);
            deg |= angle_pair(cx, cz, cos_t[1], sin_t[1]);
            rotate_pair(cx, cz, cos_t[1], sin_t[1]);
            rotate_pair(bx, bz, cos_t[1], sin_t[1]);
            deg |= angle_pair(by, bz, cos_t[2], sin_t[2]);
            rotate_pair(by, bz, cos_t[2], sin_t[2]);
            degen_flag = deg;
            push_point(bx, by, bz, 1'b0);
            push_point(cx, cy, cz, 1'b1);
            frames_seen++;
        end
        else
        begin
            bx = ax - org_x;
            by = ay - org_y;
            bz = az - org_z;
            rotate_pair(bx, by, cos_t[0], sin_t[0]);
            rotate_pair(bx, bz, cos_t[1], sin_t[1]);
            rotate_pair(by, bz, cos_t[2], sin_t[2]);
            push_point(bx, by, bz, 1'b1);
            points_seen++;
        end
    endtask

    // Predict on each accepted input word and compare each accepted result word.
    always @(posedge clk or negedge rst_n)
    begin
        point_word_t e;
        if (!rst_n)
        begin
            rotated_q.delete();
            org_x = 0;
            org_y = 0;
            org_z = 0;
            for (int i = 0; i < 3; i++)
            begin
                sin_t[i] = 0;
                cos_t[i] = longint'(1) << TF;
            end
            degen_flag = 1'b0;
            fail_count = 0;
            frames_seen = 0;
            points_seen = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word x=%h y=%h z=%h last=%b degen=%b", $time,
                             results.out_x, results.out_y, results.out_z,
                             results.is_last, results.degenerate);
                end
                else
                begin
                    e = rotated_q.pop_front();
                    if (results.out_x !== e.x || results.out_y !== e.y ||
                        results.out_z !== e.z || results.is_last !== e.last ||
                        results.degenerate !== e.degen)
                    begin
                        fail_count++;
                        $display("%0t: expected x=%h y=%h z=%h last=%b degen=%b", $time,
                                 e.x, e.y, e.z, e.last, e.degen);
                        $display("%0t: actual   x=%h y=%h z=%h last=%b degen=%b", $time,
                                 results.out_x, results.out_y, results.out_z,
                                 results.is_last, results.degenerate);
                    end
                end
            end
            if (items.valid && items.ready)
            begin
                predict_rotation();
            end
        end
    end

    assign pending_count = rotated_q.size();

endmodule

FILE: verif/tb.sv
// Testbench top of the frame rotator: stimulus, flow control, watchdog and verdict.
module tb;
    import tpfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = COORD_WIDTH_DEF;
    localparam int STALL_MAX  = 40000;
    localparam int PHASE_WORDS = 384;

    logic clk;
    logic rst_n;
    int   fail_count, pending_count, frames_seen, points_seen;
    int   send_idle, recv_idle, hold_cycles;
    int   quiet_cycles;

    tpfr_in_if  #(.COORD_WIDTH(CW)) items ();
    tpfr_out_if #(.COORD_WIDTH(CW)) results ();

    three_point_frame_rotator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    tpfr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (items),
        .results       (results),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .frames_seen   (frames_seen),
        .points_seen   (points_seen)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: random stalls plus a long hold-off on request.
    initial
    begin
        int held;
        held = 0;
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                held = hold_cycles;
                hold_cycles = 0;
            end
            if (held > 0)
            begin
                held--;
                results.ready = 1'b0;
            end
            else
            begin
                results.ready = ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("Watchdog: no word accepted for %0d cycles", STALL_MAX);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one input word, idling before it at the current rate.
    task automatic send_word(input logic fn, input logic signed [CW-1:0] pt[9]);
        while ($urandom_range(99) < send_idle)
        begin
            items.valid = 1'b0;
            @(negedge clk);
        end
        items.func = fn;
        items.p0_x = pt[0];
        items.p0_y = pt[1];
        items.p0_z = pt[2];
        items.p1_x = pt[3];
        items.p1_y = pt[4];
        items.p1_z = pt[5];
        items.p2_x = pt[6];
        items.p2_y = pt[7];
        items.p2_z = pt[8];
        items.valid = 1'b1;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        @(negedge clk);
        items.valid = 1'b0;
    endtask

    // Coordinate drawn from a mix of full range, small values, extremes and zero.
    function automatic logic signed [CW-1:0] pick_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3) return $urandom;
        if (sel < 7) return $signed($urandom_range(2097152)) - 1048576;
        if (sel == 7) return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
        if (sel == 8) return $signed($urandom_range(64)) - 32;
        return '0;
    endfunction

    // Random word: mostly well-formed frames and points, with some degenerate frames.
    task automatic send_random();
        logic signed [CW-1:0] pt[9];
        int sel;
        for (int i = 0; i < 9; i++) pt[i] = pick_coord();
        sel = $urandom_range(19);
        if (sel < 6)
        begin
            // Frame, sometimes with a zero-length projection.
            case ($urandom_range(5))
                0: for (int i = 0; i < 3; i++) pt[6+i] = pt[i];
                1: begin pt[6] = pt[0]; pt[7] = pt[1]; end
                2: for (int i = 0; i < 3; i++) pt[3+i] = pt[i];
                default: ;
            endcase
            send_word(FUNC_FRAME, pt);
        end
        else
        begin
            send_word(FUNC_XFORM, pt);
        end
    endtask

    task automatic fill_points(output logic signed [CW-1:0] pt[9], input int a0, input int a1,
                               input int a2, input int b0, input int b1, input int b2,
                               input int c0, input int c1, input int c2);
        pt[0] = a0; pt[1] = a1; pt[2] = a2;
        pt[3] = b0; pt[4] = b1; pt[5] = b2;
        pt[6] = c0; pt[7] = c1; pt[8] = c2;
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic signed [CW-1:0] pt[9];
        int mx, mn;
        mx = 32'sh7FFFFFFF;
        mn = 32'sh80000000;
        rst_n = 1'b0;
        send_idle = 21;
        recv_idle = 67;
        hold_cycles = 0;
        quiet_cycles = 0;
        items.valid = 1'b0;
        items.func = FUNC_FRAME;
        items.p0_x = '0; items.p0_y = '0; items.p0_z = '0;
        items.p1_x = '0; items.p1_y = '0; items.p1_z = '0;
        items.p2_x = '0; items.p2_y = '0; items.p2_z = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Transform before any frame, with unused points set.
        fill_points(pt, 65536, -131072, 3, mx, mn, 7, mn, mx, 1);
        send_word(FUNC_XFORM, pt);
        fill_points(pt, mx, mn, mx, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_XFORM, pt);
        // All points equal: every stage degenerate.
        fill_points(pt, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_FRAME, pt);
        fill_points(pt, 65536, 65536, 65536, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_XFORM, pt);
        // Axis along z only, then a regular frame that clears the flag.
        fill_points(pt, 0, 0, 0, 65536, 0, 0, 0, 0, 65536);
        send_word(FUNC_FRAME, pt);
        fill_points(pt, 65536, 0, 0, 0, 65536, 0, 65536, 65536, 0);
        send_word(FUNC_FRAME, pt);
        fill_points(pt, 131072, 65536, -65536, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_XFORM, pt);
        // Side point on the axis: third stage degenerate.
        fill_points(pt, 0, 0, 0, 131072, 131072, 131072, 65536, 65536, 65536);
        send_word(FUNC_FRAME, pt);
        // Extremes of every coordinate, both signs.
        fill_points(pt, mn, mn, mn, mx, mx, mx, mx, mn, mx);
        send_word(FUNC_FRAME, pt);
        fill_points(pt, mx, mx, mx, mn, mn, mn, mn, mx, mn);
        send_word(FUNC_FRAME, pt);
        fill_points(pt, mn, mx, mn, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_XFORM, pt);
        fill_points(pt, mx, mn, mx, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_XFORM, pt);
        // Negative projections and tiny offsets.
        fill_points(pt, 5, -7, 3, 4, -9, 3, 1, -7, 3);
        send_word(FUNC_FRAME, pt);
        fill_points(pt, -1, -1, -1, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_XFORM, pt);
        fill_points(pt, 0, 0, 0, -65536, 0, -65536, 0, -65536, -65536);
        send_word(FUNC_FRAME, pt);
        fill_points(pt, 1, 2, 3, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_XFORM, pt);

        // Sender idles lightly, receiver heavily.
        for (int n = 0; n < PHASE_WORDS; n++) send_random();
        wait_drained();

        // Reverse the idle rates.
        send_idle = 67;
        recv_idle = 21;
        for (int n = 0; n < PHASE_WORDS; n++) send_random();
        wait_drained();

        // No idling, with one long receiver hold-off to back up the block.
        send_idle = 0;
        recv_idle = 0;
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            if (n == 40) hold_cycles = 4000;
            send_random();
        end
        wait_drained();

        $display("Covered %0d frame words and %0d transform words under three flow patterns",
                 frames_seen, points_seen);
        $display("including degenerate frames, extreme coordinates and a long output stall.");
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
